// ===== hw/rtl/dlte_pkg.sv =====
// Shared types and saturating arithmetic helpers for the dense layer training engine.
`timescale 1ns / 1ps

package dlte_pkg;

  // Sequencer phases; also used as the operation tag that rides the pipeline.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CLEAR,
    PH_FWD_ACC,
    PH_FWD_OUT,
    PH_BG,
    PH_GRAD_ACC,
    PH_GRAD_OUT,
    PH_UPD_W,
    PH_UPD_B,
    PH_ZERO,
    PH_ACK,
    PH_DRAIN
  } phase_t;

  // Item kinds.
  localparam logic [2:0] KIND_LOAD_W = 3'd0;
  localparam logic [2:0] KIND_LOAD_B = 3'd1;
  localparam logic [2:0] KIND_FWD    = 3'd2;
  localparam logic [2:0] KIND_GRAD   = 3'd3;
  localparam logic [2:0] KIND_UPDATE = 3'd4;
  localparam logic [2:0] KIND_ZERO   = 3'd5;

  // Result kinds.
  localparam logic [1:0] RES_FWD  = 2'd0;
  localparam logic [1:0] RES_GRAD = 2'd1;
  localparam logic [1:0] RES_ACK  = 2'd2;

  localparam logic [15:0] LR_RESET = 16'd655;

  // Saturate a 41-bit sum to 40 bits.
  function automatic logic [39:0] sat40(input logic [40:0] x);
    logic [39:0] r;
    if (x[40] != x[39]) begin
      r = x[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      r = x[39:0];
    end
    return r;
  endfunction

  // Saturate a 33-bit sum to 32 bits.
  function automatic logic [31:0] sat32(input logic [32:0] x);
    logic [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Saturate a 33-bit value to 16 bits.
  function automatic logic [15:0] sat16(input logic [32:0] x);
    logic [15:0] r;
    if ((&x[32:15]) || !(|x[32:15])) begin
      r = x[15:0];
    end else begin
      r = x[32] ? 16'h8000 : 16'h7FFF;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dense_layer_train_engine_top.sv =====
// Top level of the dense layer training engine: sequencer, state memories and write-back.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; results come one per cycle on
// result_strobe and cannot be held off. The stored state sits in single-port-write memories
// walked by one sequencer, one entry per cycle, through a three-stage read, multiply and
// write-back pipeline that drains between phases. A forward element runs an accumulate
// pass, plus an output pass on a row end; a gradient element a bias-gradient step and an
// accumulate pass, plus an output pass on a row end; an update a weight pass, a bias pass
// and an acknowledge; a zero a gradient clearing pass and an acknowledge; loads write
// straight into memory. After reset a clearing pass runs with busy high.
module dense_layer_train_engine_top #(
  parameter int NUM_IN     = 16,
  parameter int NUM_OUT    = 16,
  parameter int BATCH_ROWS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic        [2:0]  kind,
  input  logic        [2:0]  batch_row,
  input  logic        [5:0]  out_index,
  input  logic        [5:0]  in_index,
  input  logic signed [15:0] value,
  input  logic               row_end,
  input  logic               cfg_we,
  input  logic        [15:0] cfg_wdata,
  output logic               result_strobe,
  output logic        [1:0]  result_kind,
  output logic        [5:0]  position,
  output logic signed [15:0] result_value,
  output logic               final_res
);
  import dlte_pkg::*;

  localparam int WN = NUM_OUT * NUM_IN;
  localparam int CN = BATCH_ROWS * NUM_IN;
  localparam int WA = (WN > 1) ? $clog2(WN) : 1;
  localparam int CA = (CN > 1) ? $clog2(CN) : 1;
  localparam int OA = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;
  localparam int IA = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
  localparam int CW = $clog2(WN + 1);

  // Control and item registers.
  phase_t state, state_next, after, after_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [15:0] lr;
  logic signed [15:0] k_v;
  logic [2:0] k_row;
  logic [5:0] k_o, k_i;
  logic k_end;

  // Pipeline registers.
  logic s1_valid, s2_valid, s1_last, s2_last;
  phase_t s1_op, s2_op;
  logic [WA-1:0] s1_flat, s2_flat;
  logic [5:0] s1_pos, s2_pos;
  logic [39:0] s2_acc;
  logic [31:0] s2_gw, s2_bg;
  logic [15:0] s2_w, s2_b;
  logic signed [31:0] pa, pb;
  logic signed [48:0] pc;

  // Memories and their ports.
  logic [15:0] wmem [WN];
  logic [31:0] gwmem [WN];
  logic [15:0] cmem [CN];
  logic [39:0] fsmem [NUM_OUT];
  logic [39:0] igmem [NUM_IN];
  logic [15:0] bmem [NUM_OUT];
  logic [31:0] bgmem [NUM_OUT];

  logic w_we, gw_we, c_we, fs_we, ig_we, b_we, bg_we;
  logic [WA-1:0] w_waddr, gw_waddr, w_raddr;
  logic [CA-1:0] c_waddr, c_raddr;
  logic [OA-1:0] fs_waddr, b_waddr, bg_waddr, o_raddr;
  logic [IA-1:0] ig_waddr, ig_raddr;
  logic [15:0] w_wdata, c_wdata, b_wdata;
  logic [31:0] gw_wdata, bg_wdata;
  logic [39:0] fs_wdata, ig_wdata;
  logic [15:0] w_rdata, c_rdata, b_rdata;
  logic [31:0] gw_rdata, bg_rdata;
  logic [39:0] fs_rdata, ig_rdata;

  // Issue-side signals.
  logic accept, iss, last_iss;
  logic [CW-1:0] len;
  logic [5:0] iss_pos, oa, ib;
  logic [WA-1:0] iss_flat;
  logic fwd_ok, grad_ok;

  // Second-stage results.
  logic [39:0] fs_sum, ig_sum;
  logic [31:0] gw_sum, bg_sum;
  logic [40:0] fwd_tot;
  logic [24:0] step;
  logic [15:0] fwd_val, grad_val, w_new, b_new;

  assign busy = (state != PH_IDLE);
  assign accept = start && !busy;
  assign fwd_ok = (32'(batch_row) < BATCH_ROWS) && (32'(in_index) < NUM_IN);
  assign grad_ok = (32'(batch_row) < BATCH_ROWS) && (32'(out_index) < NUM_OUT);

  // Phase length and issue addressing.
  always_comb begin
    unique case (state)
      PH_FWD_ACC, PH_FWD_OUT, PH_UPD_B: len = CW'(NUM_OUT);
      PH_GRAD_ACC, PH_GRAD_OUT:         len = CW'(NUM_IN);
      PH_UPD_W, PH_ZERO, PH_CLEAR:      len = CW'(WN);
      default:                          len = CW'(1);
    endcase
    last_iss = (cnt == len - CW'(1));
    iss = (state == PH_FWD_ACC) || (state == PH_FWD_OUT) || (state == PH_BG) ||
          (state == PH_GRAD_ACC) || (state == PH_GRAD_OUT) || (state == PH_UPD_W) ||
          (state == PH_UPD_B);
    oa = (state == PH_FWD_ACC) ? 6'(cnt) : k_o;
    ib = (state == PH_FWD_ACC) ? k_i : 6'(cnt);
    iss_flat = (state == PH_UPD_W) ? WA'(cnt) :
               WA'(int'(oa) * NUM_IN + int'(ib));
    iss_pos = (state == PH_BG) ? k_o : 6'(cnt);
    w_raddr = iss_flat;
    c_raddr = CA'(int'(k_row) * NUM_IN + int'(cnt));
    o_raddr = iss_pos[OA-1:0];
    ig_raddr = iss_pos[IA-1:0];
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    after_next = after;
    cnt_next = cnt;
    unique case (state)
      PH_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          priority case (kind)
            KIND_FWD: begin
              if (fwd_ok) state_next = PH_FWD_ACC;
              else if (row_end) state_next = PH_FWD_OUT;
            end
            KIND_GRAD: begin
              if (grad_ok) state_next = PH_BG;
              else if (row_end) state_next = PH_GRAD_OUT;
            end
            KIND_UPDATE: state_next = PH_UPD_W;
            KIND_ZERO:   state_next = PH_ZERO;
            default:     state_next = PH_IDLE;
          endcase
        end
      end
      PH_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = after;
          cnt_next = '0;
        end
      end
      PH_ACK: begin
        state_next = PH_DRAIN;
        after_next = PH_IDLE;
      end
      default: begin
        cnt_next = cnt + CW'(1);
        if (last_iss) begin
          state_next = PH_DRAIN;
          unique case (state)
            PH_FWD_ACC:  after_next = k_end ? PH_FWD_OUT : PH_IDLE;
            PH_BG:       after_next = PH_GRAD_ACC;
            PH_GRAD_ACC: after_next = k_end ? PH_GRAD_OUT : PH_IDLE;
            PH_UPD_W:    after_next = PH_UPD_B;
            PH_UPD_B:    after_next = PH_ACK;
            PH_ZERO:     after_next = PH_ACK;
            default:     after_next = PH_IDLE;
          endcase
        end
      end
    endcase
  end

  // Control registers, item capture and learning rate.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_CLEAR;
      after <= PH_IDLE;
      cnt <= '0;
      lr <= LR_RESET;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      state <= state_next;
      after <= after_next;
      cnt <= cnt_next;
      if (cfg_we) lr <= cfg_wdata;
      s1_valid <= iss;
      s2_valid <= s1_valid;
    end
    if (accept) begin
      k_v <= value;
      k_row <= batch_row;
      k_o <= out_index;
      k_i <= in_index;
      k_end <= row_end;
    end
  end

  // Pipeline payload: stage one tags, stage two captures read data.
  always_ff @(posedge clk) begin
    s1_op <= state;
    s1_flat <= iss_flat;
    s1_pos <= iss_pos;
    s1_last <= last_iss;
    s2_op <= s1_op;
    s2_flat <= s1_flat;
    s2_pos <= s1_pos;
    s2_last <= s1_last;
    s2_acc <= ((s1_op == PH_FWD_ACC) || (s1_op == PH_FWD_OUT)) ? fs_rdata : ig_rdata;
    s2_gw <= gw_rdata;
    s2_bg <= bg_rdata;
    s2_w <= w_rdata;
    s2_b <= b_rdata;
  end

  dlte_mul u_mul (
    .clk (clk),
    .v   (k_v),
    .a   ((s1_op == PH_GRAD_ACC) ? $signed(c_rdata) : $signed(w_rdata)),
    .w   ($signed(w_rdata)),
    .lr  (lr),
    .g   ((s1_op == PH_UPD_W) ? $signed(gw_rdata) : $signed(bg_rdata)),
    .pa  (pa),
    .pb  (pb),
    .pc  (pc)
  );

  // Stage two arithmetic.
  always_comb begin
    fs_sum = sat40({s2_acc[39], s2_acc} + {{9{pa[31]}}, pa});
    ig_sum = sat40({s2_acc[39], s2_acc} + {{9{pb[31]}}, pb});
    gw_sum = sat32({s2_gw[31], s2_gw} + {pa[31], pa});
    bg_sum = sat32({s2_bg[31], s2_bg} + {{9{k_v[15]}}, k_v, 8'd0});
    fwd_tot = {s2_acc[39], s2_acc} + {{17{s2_b[15]}}, s2_b, 8'd0};
    fwd_val = sat16(fwd_tot[40:8]);
    grad_val = sat16({s2_acc[39], s2_acc[39:8]});
    step = pc[48:24];
    w_new = sat16({{17{s2_w[15]}}, s2_w} - {{8{step[24]}}, step});
    b_new = sat16({{17{s2_b[15]}}, s2_b} - {{8{step[24]}}, step});
  end

  // Write port selection; phases never overlap, so one source drives each port.
  always_comb begin
    w_we = 1'b0; w_waddr = s2_flat; w_wdata = w_new;
    gw_we = 1'b0; gw_waddr = s2_flat; gw_wdata = gw_sum;
    c_we = 1'b0; c_waddr = CA'(int'(batch_row) * NUM_IN + int'(in_index));
    c_wdata = value;
    fs_we = 1'b0; fs_waddr = s2_pos[OA-1:0]; fs_wdata = fs_sum;
    ig_we = 1'b0; ig_waddr = s2_pos[IA-1:0]; ig_wdata = ig_sum;
    b_we = 1'b0; b_waddr = s2_pos[OA-1:0]; b_wdata = b_new;
    bg_we = 1'b0; bg_waddr = s2_pos[OA-1:0]; bg_wdata = bg_sum;
    if (accept) begin
      if (kind == KIND_LOAD_W && 32'(out_index) < NUM_OUT &&
          32'(in_index) < NUM_IN) begin
        w_we = 1'b1;
        w_waddr = WA'(int'(out_index) * NUM_IN + int'(in_index));
        w_wdata = value;
      end
      if (kind == KIND_LOAD_B && 32'(out_index) < NUM_OUT) begin
        b_we = 1'b1;
        b_waddr = OA'(out_index);
        b_wdata = value;
      end
      if (kind == KIND_FWD && fwd_ok) c_we = 1'b1;
    end
    if (state == PH_ZERO || state == PH_CLEAR) begin
      gw_we = 1'b1; gw_waddr = WA'(cnt); gw_wdata = '0;
      if (32'(cnt) < NUM_OUT) begin
        bg_we = 1'b1; bg_waddr = OA'(cnt); bg_wdata = '0;
      end
      if (state == PH_CLEAR) begin
        if (32'(cnt) < NUM_OUT) begin
          fs_we = 1'b1; fs_waddr = OA'(cnt); fs_wdata = '0;
          b_we = 1'b1; b_waddr = OA'(cnt); b_wdata = '0;
        end
        if (32'(cnt) < NUM_IN) begin
          ig_we = 1'b1; ig_waddr = IA'(cnt); ig_wdata = '0;
        end
      end
    end
    if (s2_valid) begin
      unique case (s2_op)
        PH_FWD_ACC: fs_we = 1'b1;
        PH_FWD_OUT: begin fs_we = 1'b1; fs_wdata = '0; end
        PH_BG: bg_we = 1'b1;
        PH_GRAD_ACC: begin gw_we = 1'b1; ig_we = 1'b1; end
        PH_GRAD_OUT: begin ig_we = 1'b1; ig_wdata = '0; end
        PH_UPD_W: w_we = 1'b1;
        PH_UPD_B: b_we = 1'b1;
        default: ;
      endcase
    end
  end

  // State memories with registered reads.
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata <= wmem[w_raddr];
    if (gw_we) gwmem[gw_waddr] <= gw_wdata;
    gw_rdata <= gwmem[w_raddr];
    if (c_we) cmem[c_waddr] <= c_wdata;
    c_rdata <= cmem[c_raddr];
    if (fs_we) fsmem[fs_waddr] <= fs_wdata;
    fs_rdata <= fsmem[o_raddr];
    if (ig_we) igmem[ig_waddr] <= ig_wdata;
    ig_rdata <= igmem[ig_raddr];
    if (b_we) bmem[b_waddr] <= b_wdata;
    b_rdata <= bmem[o_raddr];
    if (bg_we) bgmem[bg_waddr] <= bg_wdata;
    bg_rdata <= bgmem[o_raddr];
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == PH_ACK) ||
                       (s2_valid && (s2_op == PH_FWD_OUT || s2_op == PH_GRAD_OUT));
    end
    if (state == PH_ACK) begin
      result_kind <= RES_ACK;
      position <= '0;
      result_value <= '0;
      final_res <= 1'b1;
    end else begin
      result_kind <= (s2_op == PH_FWD_OUT) ? RES_FWD : RES_GRAD;
      position <= s2_pos;
      result_value <= (s2_op == PH_FWD_OUT) ? fwd_val : grad_val;
      final_res <= s2_last;
    end
  end

endmodule

// ===== hw/rtl/dlte_mul.sv =====
// Registered multiplier bank of the engine's second pipeline stage.
`timescale 1ns / 1ps

module dlte_mul (
  input  logic               clk,
  input  logic signed [15:0] v,
  input  logic signed [15:0] a,
  input  logic signed [15:0] w,
  input  logic        [15:0] lr,
  input  logic signed [31:0] g,
  output logic signed [31:0] pa,
  output logic signed [31:0] pb,
  output logic signed [48:0] pc
);

  // Item value times input or weight, value times weight, rate times gradient.
  always_ff @(posedge clk) begin
    pa <= v * a;
    pb <= v * w;
    pc <= $signed({1'b0, lr}) * g;
  end

endmodule

// ===== hw/rtl/dlte_checker.sv =====
// Port-level checker for the dense layer training engine and its bind.
`timescale 1ns / 1ps

module dlte_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  kind,
  input logic        result_strobe,
  input logic [1:0]  result_kind,
  input logic [5:0]  position,
  input logic [15:0] result_value,
  input logic        final_res
);
  import dlte_pkg::*;

  // A result word only appears while a command is in progress.
  a_word_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy) else $error("result word while idle");

  // The last word of a command is followed by a quiet cycle.
  a_final_gap: assert property (@(posedge clk) disable iff (rst)
    result_strobe && final_res |=> !result_strobe) else $error("word after final");

  // An acknowledge is a single empty word.
  a_ack_form: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result_kind == RES_ACK |->
      final_res && position == 6'd0 && result_value == 16'd0)
    else $error("malformed acknowledge");

  // A zero command always runs a sweep.
  a_zero_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_ZERO |=> busy) else $error("zero not taken");

  // No word right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_strobe) else $error("word after reset");

endmodule

bind dense_layer_train_engine_top dlte_checker u_dlte_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .kind          (kind),
  .result_strobe (result_strobe),
  .result_kind   (result_kind),
  .position      (position),
  .result_value  (result_value),
  .final_res     (final_res)
);
